>>> rtl/core/dpbf_pkg.sv
package dpbf_pkg;

    // Pixel indexes keep only their low COORD_BITS bits.
    localparam int COORD_BITS = 11;
    localparam int PIX_W      = 11;
    localparam logic [PIX_W-1:0] PIX_MASK = PIX_W'((64'd1 << COORD_BITS) - 64'd1);

    localparam int DEPTH_W = 16;
    localparam int CTR_W   = 15;
    localparam int DEN_W   = 16;
    localparam int LIM_W   = 17;
    localparam int COL_W   = 8;
    localparam int PT_W    = 18;

    // Offset 16*pix - centre is signed; its magnitude fits in OFF_W-1 bits.
    localparam int OFF_W   = CTR_W + 2;
    localparam int MAG_W   = OFF_W - 1;

    // Quotients are only needed below 2**QBITS; anything larger is out of the box.
    localparam int QBITS   = 17;
    localparam int NUM_W   = MAG_W + QBITS;
    localparam int DIV_LAT = QBITS;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEPTH_SCALE = 3'd0,
        CFG_CENTER_X    = 3'd1,
        CFG_CENTER_Y    = 3'd2,
        CFG_FOCAL_X     = 3'd3,
        CFG_FOCAL_Y     = 3'd4,
        CFG_BOX_LIMIT   = 3'd5
    } t_cfg_idx;

    // Divisors here already have zero replaced by one.
    typedef struct packed {
        logic [DEN_W-1:0] depth_scale;
        logic [CTR_W-1:0] center_x;
        logic [CTR_W-1:0] center_y;
        logic [DEN_W-1:0] focal_x;
        logic [DEN_W-1:0] focal_y;
        logic [LIM_W-1:0] box_limit;
    } t_cfg;

endpackage

>>> rtl/core/dpbf_cfg.sv
module dpbf_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [dpbf_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [dpbf_pkg::CFG_DAT_W-1:0]   i_cfg_data,
    output dpbf_pkg::t_cfg                   o_cfg
);

    logic [dpbf_pkg::DEN_W-1:0] r_depth_scale;
    logic [dpbf_pkg::CTR_W-1:0] r_center_x;
    logic [dpbf_pkg::CTR_W-1:0] r_center_y;
    logic [dpbf_pkg::DEN_W-1:0] r_focal_x;
    logic [dpbf_pkg::DEN_W-1:0] r_focal_y;
    logic [dpbf_pkg::LIM_W-1:0] r_box_limit;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth_scale <= 16'd1000;
            r_center_x    <= 15'd5120;
            r_center_y    <= 15'd3840;
            r_focal_x     <= 16'd9728;
            r_focal_y     <= 16'd9728;
            r_box_limit   <= 17'd65536;
        end else if (i_cfg_valid) begin
            unique case (dpbf_pkg::t_cfg_idx'(i_cfg_index))
                dpbf_pkg::CFG_DEPTH_SCALE: r_depth_scale <= i_cfg_data[15:0];
                dpbf_pkg::CFG_CENTER_X:    r_center_x    <= i_cfg_data[14:0];
                dpbf_pkg::CFG_CENTER_Y:    r_center_y    <= i_cfg_data[14:0];
                dpbf_pkg::CFG_FOCAL_X:     r_focal_x     <= i_cfg_data[15:0];
                dpbf_pkg::CFG_FOCAL_Y:     r_focal_y     <= i_cfg_data[15:0];
                dpbf_pkg::CFG_BOX_LIMIT:   r_box_limit   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A zero divisor behaves as one.
    always_comb begin
        o_cfg.depth_scale = (r_depth_scale == '0) ? 16'd1 : r_depth_scale;
        o_cfg.center_x    = r_center_x;
        o_cfg.center_y    = r_center_y;
        o_cfg.focal_x     = (r_focal_x == '0) ? 16'd1 : r_focal_x;
        o_cfg.focal_y     = (r_focal_y == '0) ? 16'd1 : r_focal_y;
        o_cfg.box_limit   = r_box_limit;
    end

endmodule

>>> rtl/core/dpbf_div.sv
module dpbf_div (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [dpbf_pkg::NUM_W-1:0]   i_num,
    input  logic [dpbf_pkg::DEN_W-1:0]   i_den,
    output logic [dpbf_pkg::QBITS-1:0]   o_quo
);

    // Restoring division, one quotient bit per stage, most significant first.
    // The caller guarantees i_num < i_den * 2**QBITS for a meaningful result.
    logic [dpbf_pkg::NUM_W-1:0] r_rem [dpbf_pkg::QBITS];
    logic [dpbf_pkg::QBITS-1:0] r_quo [dpbf_pkg::QBITS];

    for (genvar k = 0; k < dpbf_pkg::QBITS; k++) begin : g_stage
        logic [dpbf_pkg::NUM_W-1:0] w_rem_in;
        logic [dpbf_pkg::QBITS-1:0] w_quo_in;
        logic [dpbf_pkg::NUM_W-1:0] w_dsh;
        logic                       w_ge;

        if (k == 0) begin : g_first
            assign w_rem_in = i_num;
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[k-1];
            assign w_quo_in = r_quo[k-1];
        end

        assign w_dsh = dpbf_pkg::NUM_W'(i_den) << (dpbf_pkg::QBITS - 1 - k);
        assign w_ge  = (w_rem_in >= w_dsh);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= w_ge ? (w_rem_in - w_dsh) : w_rem_in;
                r_quo[k] <= {w_quo_in[dpbf_pkg::QBITS-2:0], w_ge};
            end
        end
    end

    assign o_quo = r_quo[dpbf_pkg::QBITS-1];

endmodule

>>> rtl/core/depth_pixel_backprojection_filter_unit.sv
// Depth pixel back-projection filter.
//
// The slave stream takes one depth pixel per word; the master stream gives one
// camera-frame point with its colour per word. A pixel with zero depth, and a
// point with any coordinate outside +/-box_limit, gives no output word.
// Configuration is written through i_cfg_* (always ready) while the block is
// idle; reset loads the default camera intrinsics and a box of one metre.
//
// The datapath is a 38-stage pipeline: input register, a 17-stage divider for
// z, a multiply stage, an overflow pre-check stage, two 17-stage dividers for
// x and y working side by side, and the output register. One word can enter
// every cycle while the receiver does not hold i_m_tready low.
// The three dividers set the depth: one quotient bit per stage.
//
// Reset clears every valid bit, so the pipeline comes up empty. When the
// receiver holds i_m_tready low with a word waiting, the whole pipeline
// freezes and o_s_tready drops; nothing is lost or repeated, and it resumes
// in the same cycle that i_m_tready returns.
module depth_pixel_backprojection_filter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // depth[15:0], row[26:16], col[37:27], blue[45:38], green[53:46], red[61:54]
    input  logic [63:0] i_s_tdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // point_x[17:0], point_y[35:18], point_z[53:36], out_blue[61:54],
    // out_green[69:62], out_red[77:70]
    output logic [79:0] o_m_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [16:0] i_cfg_data
);

    localparam int LAT = dpbf_pkg::DIV_LAT;

    typedef struct packed {
        logic                             zovf;
        logic signed [dpbf_pkg::OFF_W-1:0] offx;
        logic signed [dpbf_pkg::OFF_W-1:0] offy;
        logic [3*dpbf_pkg::COL_W-1:0]     rgb;
    } t_zside;

    typedef struct packed {
        logic                         ovf;
        logic                         negx;
        logic                         negy;
        logic [dpbf_pkg::QBITS-1:0]   zq;
        logic [3*dpbf_pkg::COL_W-1:0] rgb;
    } t_xyside;

    dpbf_pkg::t_cfg w_cfg;
    logic           w_en;

    dpbf_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // The whole pipeline advances unless a finished word is being held back.
    logic r_o_valid;
    assign w_en       = !r_o_valid || i_m_tready;
    assign o_s_tready = w_en;

    // Input stage: split the word, mask the pixel indexes, form offsets.
    logic [dpbf_pkg::DEPTH_W-1:0] w_depth;
    logic [dpbf_pkg::PIX_W-1:0]   w_row;
    logic [dpbf_pkg::PIX_W-1:0]   w_col;

    assign w_depth = i_s_tdata[15:0];
    assign w_row   = i_s_tdata[26:16] & dpbf_pkg::PIX_MASK;
    assign w_col   = i_s_tdata[37:27] & dpbf_pkg::PIX_MASK;

    logic                           r_a_valid;
    logic [dpbf_pkg::NUM_W-1:0]     r_a_num;
    t_zside                         r_a_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (w_en) begin
            r_a_valid <= i_s_tvalid && (w_depth != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a_num       <= dpbf_pkg::NUM_W'({w_depth, 16'h0000});
            // z is at least 2**17 exactly when depth >= 2 * depth_scale.
            r_a_side.zovf <= ({1'b0, w_depth} >= {w_cfg.depth_scale, 1'b0});
            r_a_side.offx <= $signed({2'b00, w_col, 4'h0})
                             - $signed({2'b00, w_cfg.center_x});
            r_a_side.offy <= $signed({2'b00, w_row, 4'h0})
                             - $signed({2'b00, w_cfg.center_y});
            r_a_side.rgb  <= i_s_tdata[61:38];
        end
    end

    // z divider with its side data carried alongside.
    logic [dpbf_pkg::QBITS-1:0] w_zq;

    dpbf_div u_div_z (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_a_num),
        .i_den (w_cfg.depth_scale),
        .o_quo (w_zq)
    );

    logic   r_zd_valid [LAT];
    t_zside r_zd_side  [LAT];

    for (genvar k = 0; k < LAT; k++) begin : g_zd
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_zd_valid[k] <= 1'b0;
            end else if (w_en) begin
                r_zd_valid[k] <= (k == 0) ? r_a_valid : r_zd_valid[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_zd_side[k] <= (k == 0) ? r_a_side : r_zd_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Multiply stage: magnitude of offset times z.
    t_zside                     w_zs;
    logic [dpbf_pkg::MAG_W-1:0] w_absx;
    logic [dpbf_pkg::MAG_W-1:0] w_absy;

    assign w_zs   = r_zd_side[LAT-1];
    assign w_absx = w_zs.offx[dpbf_pkg::OFF_W-1] ? dpbf_pkg::MAG_W'(-w_zs.offx)
                                                 : dpbf_pkg::MAG_W'(w_zs.offx);
    assign w_absy = w_zs.offy[dpbf_pkg::OFF_W-1] ? dpbf_pkg::MAG_W'(-w_zs.offy)
                                                 : dpbf_pkg::MAG_W'(w_zs.offy);

    logic                       r_m_valid;
    logic [dpbf_pkg::NUM_W-1:0] r_m_magx;
    logic [dpbf_pkg::NUM_W-1:0] r_m_magy;
    t_xyside                    r_m_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= r_zd_valid[LAT-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_magx      <= dpbf_pkg::NUM_W'(w_absx) * dpbf_pkg::NUM_W'(w_zq);
            r_m_magy      <= dpbf_pkg::NUM_W'(w_absy) * dpbf_pkg::NUM_W'(w_zq);
            r_m_side.ovf  <= w_zs.zovf;
            r_m_side.negx <= w_zs.offx[dpbf_pkg::OFF_W-1];
            r_m_side.negy <= w_zs.offy[dpbf_pkg::OFF_W-1];
            r_m_side.zq   <= w_zq;
            r_m_side.rgb  <= w_zs.rgb;
        end
    end

    // Pre-check stage: a quotient of 2**17 or more can never lie in the box.
    logic                       r_c_valid;
    logic [dpbf_pkg::NUM_W-1:0] r_c_magx;
    logic [dpbf_pkg::NUM_W-1:0] r_c_magy;
    t_xyside                    r_c_side;
    t_xyside                    w_c_next;

    always_comb begin
        w_c_next     = r_m_side;
        w_c_next.ovf = r_m_side.ovf
            || (r_m_magx >= (dpbf_pkg::NUM_W'(w_cfg.focal_x) << dpbf_pkg::QBITS))
            || (r_m_magy >= (dpbf_pkg::NUM_W'(w_cfg.focal_y) << dpbf_pkg::QBITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (w_en) begin
            r_c_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c_magx <= r_m_magx;
            r_c_magy <= r_m_magy;
            r_c_side <= w_c_next;
        end
    end

    // x and y dividers.
    logic [dpbf_pkg::QBITS-1:0] w_qx;
    logic [dpbf_pkg::QBITS-1:0] w_qy;

    dpbf_div u_div_x (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_c_magx),
        .i_den (w_cfg.focal_x),
        .o_quo (w_qx)
    );

    dpbf_div u_div_y (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_c_magy),
        .i_den (w_cfg.focal_y),
        .o_quo (w_qy)
    );

    logic    r_xd_valid [LAT];
    t_xyside r_xd_side  [LAT];

    for (genvar k = 0; k < LAT; k++) begin : g_xd
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_xd_valid[k] <= 1'b0;
            end else if (w_en) begin
                r_xd_valid[k] <= (k == 0) ? r_c_valid : r_xd_valid[(k == 0) ? 0 : k-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_xd_side[k] <= (k == 0) ? r_c_side : r_xd_side[(k == 0) ? 0 : k-1];
            end
        end
    end

    // Output stage: box test, sign restore, and the output register.
    t_xyside                  w_xs;
    logic                     w_pass;
    logic [dpbf_pkg::PT_W-1:0] w_px;
    logic [dpbf_pkg::PT_W-1:0] w_py;

    assign w_xs   = r_xd_side[LAT-1];
    assign w_pass = r_xd_valid[LAT-1] && !w_xs.ovf
                    && (w_qx <= w_cfg.box_limit)
                    && (w_qy <= w_cfg.box_limit)
                    && (w_xs.zq <= w_cfg.box_limit);
    assign w_px   = w_xs.negx ? -{1'b0, w_qx} : {1'b0, w_qx};
    assign w_py   = w_xs.negy ? -{1'b0, w_qy} : {1'b0, w_qy};

    logic [79:0] r_o_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_en) begin
            r_o_valid <= w_pass;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_o_data <= {2'b00, w_xs.rgb, 1'b0, w_xs.zq, w_py, w_px};
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

endmodule

>>> rtl/core/dpbf_checker.sv
module dpbf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic [79:0] o_m_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready
);

    // A held word does not change.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("output word changed while stalled");

    // The input side only stalls behind a held output word.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // z is never negative.
    a_zpos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_m_tdata[53])
        else $error("negative z");

    // A point at zero distance lies on the optical axis.
    a_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tdata[53:36] == 18'd0)
        |-> (o_m_tdata[17:0] == 18'd0) && (o_m_tdata[35:18] == 18'd0))
        else $error("nonzero x or y at zero z");

    // The pipeline is empty right after reset.
    a_rst: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind depth_pixel_backprojection_filter_unit dpbf_checker u_dpbf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready)
);

>>> test/testbench.sv
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // Number of pipeline stages in the block.
    localparam int PIPE_DEPTH = 38;
    localparam int CYCLE_LIMIT = 400000;

    // Packed from the top bit down, so x lands in the lowest bits of the word.
    typedef struct packed {
        logic [dpbf_pkg::COL_W-1:0] red;
        logic [dpbf_pkg::COL_W-1:0] green;
        logic [dpbf_pkg::COL_W-1:0] blue;
        logic signed [dpbf_pkg::PT_W-1:0] z;
        logic signed [dpbf_pkg::PT_W-1:0] y;
        logic signed [dpbf_pkg::PT_W-1:0] x;
    } t_point;

    logic clk;
    logic rst_n;
    logic [63:0] s_tdata;
    logic s_tvalid;
    logic s_tready;
    logic [79:0] m_tdata;
    logic m_tvalid;
    logic m_tready;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [16:0] cfg_data;

    // Shadow copy of the camera setup, as the block should hold it.
    logic [15:0] cam_scale;
    logic [14:0] cam_cx;
    logic [14:0] cam_cy;
    logic [15:0] cam_fx;
    logic [15:0] cam_fy;
    logic [16:0] cam_box;

    t_point points_due[$];
    int unsigned cycles;
    int unsigned points_seen;
    bit failed;
    bit calm;

    depth_pixel_backprojection_filter_unit dut (
        .i_clk(clk),
        .i_rst_n(rst_n),
        // depth[15:0], row[26:16], col[37:27], blue[45:38], green[53:46], red[61:54]
        .i_s_tdata(s_tdata),
        .i_s_tvalid(s_tvalid),
        .o_s_tready(s_tready),
        // point_x[17:0], point_y[35:18], point_z[53:36], out_blue[61:54],
        // out_green[69:62], out_red[77:70]
        .o_m_tdata(m_tdata),
        .o_m_tvalid(m_tvalid),
        .i_m_tready(m_tready),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    always begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Cycle counter doubles as the watchdog.
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Signed quotient truncated toward zero; a zero divisor acts as one.
    function automatic longint quot_trunc(longint num, logic [15:0] den);
        longint d;
        longint mag;
        d = (den == 0) ? 1 : longint'(den);
        mag = (num < 0) ? -num : num;
        mag = mag / d;
        return (num < 0) ? -mag : mag;
    endfunction

    // Back-projects one pixel word and queues its point when it lands in the box.
    task automatic predict_point(logic [63:0] word);
        logic [15:0] depth;
        logic [10:0] row;
        logic [10:0] col;
        longint zq;
        longint xq;
        longint yq;
        longint lim;
        t_point p;
        depth = word[15:0];
        row = word[26:16] & dpbf_pkg::PIX_MASK;
        col = word[37:27] & dpbf_pkg::PIX_MASK;
        lim = longint'(cam_box);
        if (depth == 0) return;
        zq = (longint'(depth) << 16) / ((cam_scale == 0) ? 1 : longint'(cam_scale));
        xq = quot_trunc((longint'(col) * 16 - longint'(cam_cx)) * zq, cam_fx);
        yq = quot_trunc((longint'(row) * 16 - longint'(cam_cy)) * zq, cam_fy);
        if (xq < -lim || xq > lim || yq < -lim || yq > lim || zq > lim) return;
        p.x = xq[dpbf_pkg::PT_W-1:0];
        p.y = yq[dpbf_pkg::PT_W-1:0];
        p.z = zq[dpbf_pkg::PT_W-1:0];
        p.blue = word[45:38];
        p.green = word[53:46];
        p.red = word[61:54];
        points_due = {points_due, p};
    endtask

    // Receiver: random stalls, then checks each accepted word against the oldest point.
    initial begin
        int hold;
        t_point got;
        t_point want;
        m_tready = 1'b0;
        hold = 0;
        forever begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready) begin
                got = m_tdata[77:0];
                points_seen++;
                if (points_due.size() == 0) begin
                    $display("%0t: unexpected word, actual %h", $time, got);
                    failed = 1'b1;
                end else begin
                    want = points_due.pop_front();
                    if (got.x !== want.x)
                        $display("%0t: x expected %0d actual %0d", $time, want.x, got.x);
                    if (got.y !== want.y)
                        $display("%0t: y expected %0d actual %0d", $time, want.y, got.y);
                    if (got.z !== want.z)
                        $display("%0t: z expected %0d actual %0d", $time, want.z, got.z);
                    if (got.blue !== want.blue)
                        $display("%0t: blue expected %h actual %h", $time, want.blue, got.blue);
                    if (got.green !== want.green)
                        $display("%0t: green expected %h actual %h", $time, want.green,
                                 got.green);
                    if (got.red !== want.red)
                        $display("%0t: red expected %h actual %h", $time, want.red, got.red);
                    if (got !== want) failed = 1'b1;
                end
            end
            if (hold > 0) begin
                hold--;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(0, 10);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Sends one pixel word, with an occasional random gap in front of it.
    // The valid line stays high on return; the next send or a drain drops it.
    task automatic send_pixel(logic [63:0] word);
        int gap;
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= word;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
        predict_point(word);
    endtask

    function automatic logic [63:0] pixel_word(logic [15:0] depth, logic [10:0] row,
                                               logic [10:0] col, logic [23:0] bgr);
        return {2'b00, bgr[23:16], bgr[15:8], bgr[7:0], col, row, depth};
    endfunction

    // Waits for the pipeline to drain fully so that registers may be rewritten.
    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        while (points_due.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 8) @(posedge clk);
    endtask

    // The valid line stays high on return; the caller drops it after the last write.
    task automatic write_reg(dpbf_pkg::t_cfg_idx idx, logic [16:0] value);
        cfg_index <= idx;
        cfg_data <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            dpbf_pkg::CFG_DEPTH_SCALE: cam_scale = value[15:0];
            dpbf_pkg::CFG_CENTER_X: cam_cx = value[14:0];
            dpbf_pkg::CFG_CENTER_Y: cam_cy = value[14:0];
            dpbf_pkg::CFG_FOCAL_X: cam_fx = value[15:0];
            dpbf_pkg::CFG_FOCAL_Y: cam_fy = value[15:0];
            dpbf_pkg::CFG_BOX_LIMIT: cam_box = value;
            default: ;
        endcase
    endtask

    task automatic setup_camera(logic [15:0] ds, logic [14:0] cx, logic [14:0] cy,
                                logic [15:0] fx, logic [15:0] fy, logic [16:0] box);
        drain_pipe();
        write_reg(dpbf_pkg::CFG_DEPTH_SCALE, 17'(ds));
        write_reg(dpbf_pkg::CFG_CENTER_X, 17'(cx));
        write_reg(dpbf_pkg::CFG_CENTER_Y, 17'(cy));
        write_reg(dpbf_pkg::CFG_FOCAL_X, 17'(fx));
        write_reg(dpbf_pkg::CFG_FOCAL_Y, 17'(fy));
        write_reg(dpbf_pkg::CFG_BOX_LIMIT, box);
        cfg_valid <= 1'b0;
    endtask

    // Random pixel whose depth mostly lands near the box so that many points survive.
    function automatic logic [63:0] random_pixel();
        logic [15:0] depth;
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 9))
            0: depth = 16'($urandom);
            1: depth = 16'(0);
            default: depth = 16'($urandom_range(1, (cam_scale == 0) ? 2 : cam_scale + 1));
        endcase
        return pixel_word(depth, 11'($urandom), 11'($urandom), 24'(r));
    endfunction

    // Directed: field extremes, zero depth, box edges and the default setup.
    task automatic test_directed();
        send_pixel(pixel_word(16'd0, 11'd100, 11'd100, 24'hffffff));
        send_pixel(pixel_word(16'd1000, 11'd240, 11'd320, 24'h123456));
        send_pixel(pixel_word(16'd1, 11'd0, 11'd0, 24'h000000));
        send_pixel(pixel_word(16'hffff, 11'h7ff, 11'h7ff, 24'hffffff));
        send_pixel(pixel_word(16'd1000, 11'd0, 11'h7ff, 24'ha5a5a5));
        send_pixel(pixel_word(16'd1000, 11'h7ff, 11'd0, 24'h5a5a5a));
        send_pixel(pixel_word(16'd1001, 11'd240, 11'd320, 24'h0f0f0f));
        send_pixel(pixel_word(16'd500, 11'd480, 11'd640, 24'hf0f0f0));
    endtask

    // Zero divisors act as one; with a zero box no point survives, as z is above zero.
    task automatic test_corner_setups();
        setup_camera(16'd0, 15'd0, 15'd0, 16'd0, 16'd0, 17'd0);
        send_pixel(pixel_word(16'd1, 11'd0, 11'd0, 24'h010203));
        send_pixel(pixel_word(16'd1, 11'd0, 11'd1, 24'h040506));
        setup_camera(16'hffff, 15'h7fff, 15'h7fff, 16'hffff, 16'hffff, 17'h1ffff);
        send_pixel(pixel_word(16'hffff, 11'd0, 11'd0, 24'hffffff));
        send_pixel(pixel_word(16'hffff, 11'h7ff, 11'h7ff, 24'h000000));
        send_pixel(pixel_word(16'd1, 11'd5, 11'd9, 24'h777777));
        setup_camera(16'd1, 15'd0, 15'd0, 16'hffff, 16'hffff, 17'h1ffff);
        send_pixel(pixel_word(16'd1, 11'h7ff, 11'h7ff, 24'habcdef));
        send_pixel(pixel_word(16'd2, 11'd1, 11'd1, 24'h123123));
        // An unknown register index must leave the setup alone.
        drain_pipe();
        write_reg(dpbf_pkg::t_cfg_idx'(3'd7), 17'd5);
        write_reg(dpbf_pkg::t_cfg_idx'(3'd6), 17'h1ffff);
        cfg_valid <= 1'b0;
        send_pixel(pixel_word(16'd1, 11'd3, 11'd2, 24'h654321));
    endtask

    // Random pixels over several random camera setups.
    task automatic test_random(int phases, int per_phase);
        for (int ph = 0; ph < phases; ph++) begin
            setup_camera(16'($urandom_range(1, 4000)), 15'($urandom), 15'($urandom),
                         16'($urandom_range(1, 20000)), 16'($urandom_range(1, 20000)),
                         17'($urandom_range(0, 17'h1ffff)));
            for (int i = 0; i < per_phase; i++) send_pixel(random_pixel());
        end
    endtask

    // Back to the reset camera at full rate with no idling anywhere.
    task automatic test_full_rate();
        setup_camera(16'd1000, 15'd5120, 15'd3840, 16'd9728, 16'd9728, 17'd65536);
        calm = 1'b1;
        for (int i = 0; i < 150; i++)
            send_pixel(pixel_word(16'($urandom_range(0, 1200)), 11'($urandom_range(0, 480)),
                                  11'($urandom_range(0, 640)), 24'($urandom)));
    endtask

    initial begin
        rst_n <= 1'b0;
        s_tdata <= '0;
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        cycles = 0;
        points_seen = 0;
        failed = 1'b0;
        calm = 1'b0;
        cam_scale = 16'd1000;
        cam_cx = 15'd5120;
        cam_cy = 15'd3840;
        cam_fx = 16'd9728;
        cam_fy = 16'd9728;
        cam_box = 17'd65536;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_corner_setups();
        test_random(8, 100);
        test_full_rate();

        drain_pipe();
        if (!failed) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
